[design/fasta_stream_parser_defines.svh]
// Assertion macros shared by the checker files of the FASTA stream parser.
`ifndef FASTA_STREAM_PARSER_DEFINES_SVH
`define FASTA_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fsp_pkg.sv]
// Types, codes and character helpers shared by the FASTA stream parser files.
package fsp_pkg;

  localparam int unsigned HELD_DEPTH_DEF = 8;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_SEQ     = 2'd1,
    KIND_REC_END = 2'd2,
    KIND_ERROR   = 2'd3
  } out_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_EMPTY_SEQ    = 3'd1,
    ERR_EMPTY_NAME   = 3'd2,
    ERR_ILLEGAL_CHAR = 3'd3,
    ERR_WS_OVERFLOW  = 3'd4
  } err_code_e;

  // Controller to datapath.
  typedef struct packed {
    logic      in_load;
    logic      push;
    out_kind_e kind;
    err_code_e err;
    logic      last;
    logic      from_held;
    logic      seq_inc;
    logic      seq_clr;
    logic      id_inc;
    logic      line_inc;
    logic      line_rst;
    logic      held_wr;
    logic      held_clr;
    logic      flush_start;
    logic      flush_step;
  } fsp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic eoi;
    logic is_nl;
    logic is_blank;
    logic is_space;
    logic is_gt;
    logic seq_ok;
    logic seq_zero;
    logic held_zero;
    logic held_full;
    logic flush_last;
    logic out_free;
  } fsp_status_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b inside {[CHAR_TAB:CHAR_CR]});
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] b);
    return (b inside {[CHAR_LC_A:CHAR_LC_Z]}) ? (b - CASE_DELTA) : b;
  endfunction

  // Nucleotide alphabet ACGTURYKMSWBDHNX and the gap '-'.
  function automatic logic in_alphabet(input logic [7:0] c);
    logic hit;
    case (c) inside
      8'h41, 8'h43, 8'h47, 8'h54, 8'h55, 8'h52, 8'h59, 8'h4B, 8'h4D,
      8'h53, 8'h57, 8'h42, 8'h44, 8'h48, 8'h4E, 8'h58, 8'h2D: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

[design/fasta_stream_parser.sv]
// Timing: a request is registered on accept (S_IDLE) and decided in S_EXEC, which loads the
//   result register; held name whitespace replays first, through S_FLUSH and S_CHAR.
// Throughput: a new byte is accepted only after the last one is decided; held whitespace
//   is replayed from the held RAM one entry per cycle while the result register is free.
// Reset: rst_ni is asynchronous, active low; clears parser state, id to 0, line to 1.
//   The held-whitespace RAM needs no clearing pass.
module fasta_stream_parser #(
  parameter int unsigned HELD_DEPTH = fsp_pkg::HELD_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: first record id
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_input_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_char_o,
  output logic [31:0] record_id_o,
  output logic [31:0] seq_length_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] line_number_o,
  output logic        out_last_o
);
  import fsp_pkg::*;

  // The controller tracks where on the line we are (line start, header name,
  // after the name-ending space, sequence, rest of header) plus the sticky
  // error flag. It never looks at data: it sees classified byte status and
  // issues one command bundle per cycle.
  fsp_cmd_t    cmd;
  fsp_status_t status;

  fsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath owns the request register, sequence/line/id counters, the
  // held-whitespace RAM (tabs and CR/VT/FF inside a name, replayed when the
  // next non-blank byte arrives) and the output register that decouples the two channels.
  fsp_datapath #(
    .HELD_DEPTH (HELD_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_in_i      (byte_in_i),
    .end_of_input_i (end_of_input_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_kind_o     (out_kind_o),
    .out_char_o     (out_char_o),
    .record_id_o    (record_id_o),
    .seq_length_o   (seq_length_o),
    .error_code_o   (error_code_o),
    .line_number_o  (line_number_o),
    .out_last_o     (out_last_o)
  );

endmodule

[design/fsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/fsp_datapath.sv]
// Datapath: request register, counters, held-whitespace RAM and result register.
module fsp_datapath #(
  parameter int unsigned HELD_DEPTH = fsp_pkg::HELD_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          byte_in_i,
  input  logic                end_of_input_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  fsp_pkg::fsp_cmd_t   cmd_i,
  output fsp_pkg::fsp_status_t status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          out_kind_o,
  output logic [7:0]          out_char_o,
  output logic [31:0]         record_id_o,
  output logic [31:0]         seq_length_o,
  output logic [2:0]          error_code_o,
  output logic [31:0]         line_number_o,
  output logic                out_last_o
);
  import fsp_pkg::*;

  localparam int unsigned AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HELD_DEPTH + 1);

  logic [7:0]    byte_q;
  logic          eoi_q;
  logic [31:0]   seq_count_q, seq_count_d;
  logic [31:0]   current_id_q, current_id_d;
  logic [31:0]   line_count_q, line_count_d;
  logic [CW-1:0] held_count_q, held_count_d;
  logic [CW-1:0] flush_idx_q, flush_idx_d;
  logic [CW-1:0] next_idx;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_char_q;
  logic [31:0]   record_id_q;
  logic [31:0]   seq_length_q;
  logic [2:0]    error_code_q;
  logic [31:0]   line_number_q;
  logic          out_last_q;
  logic [7:0]    upper;
  logic [7:0]    held_rd;
  logic [7:0]    char_sel;
  logic          out_free;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign upper    = upcase(byte_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign next_idx = flush_idx_q + CW'(1);

  assign status_o.eoi        = eoi_q;
  assign status_o.is_nl      = (byte_q == CHAR_NL);
  assign status_o.is_blank   = is_blank(byte_q);
  assign status_o.is_space   = (byte_q == CHAR_SPACE);
  assign status_o.is_gt      = (byte_q == CHAR_GT);
  assign status_o.seq_ok     = in_alphabet(upper);
  assign status_o.seq_zero   = (seq_count_q == '0);
  assign status_o.held_zero  = (held_count_q == '0);
  assign status_o.held_full  = (held_count_q == CW'(HELD_DEPTH));
  assign status_o.flush_last = (next_idx == held_count_q);
  assign status_o.out_free   = out_free;

  // Read address 0 on flush start, then walk forward one entry per emitted byte.
  assign rd_en   = cmd_i.flush_start || cmd_i.flush_step;
  assign rd_addr = cmd_i.flush_start ? '0 : next_idx[AW-1:0];

  fsp_ram #(
    .WIDTH (8),
    .DEPTH (HELD_DEPTH)
  ) u_held_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.held_wr),
    .wr_addr_i (held_count_q[AW-1:0]),
    .wr_data_i (byte_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (held_rd)
  );

  always_comb begin
    seq_count_d = seq_count_q;
    if (cmd_i.seq_clr) begin
      seq_count_d = '0;
    end else if (cmd_i.seq_inc && (seq_count_q != '1)) begin
      seq_count_d = seq_count_q + 32'd1;
    end

    current_id_d = current_id_q;
    if (cfg_we_i) begin
      current_id_d = cfg_wdata_i;
    end else if (cmd_i.id_inc) begin
      current_id_d = current_id_q + 32'd1;
    end

    line_count_d = line_count_q;
    if (cmd_i.line_rst) begin
      line_count_d = 32'd1;
    end else if (cmd_i.line_inc && (line_count_q != '1)) begin
      line_count_d = line_count_q + 32'd1;
    end

    held_count_d = held_count_q;
    if (cmd_i.held_clr) begin
      held_count_d = '0;
    end else if (cmd_i.held_wr) begin
      held_count_d = held_count_q + CW'(1);
    end

    flush_idx_d = flush_idx_q;
    if (cmd_i.flush_start) begin
      flush_idx_d = '0;
    end else if (cmd_i.flush_step) begin
      flush_idx_d = next_idx;
    end

    out_valid_d = out_valid_q;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (cmd_i.kind)
      KIND_NAME: char_sel = cmd_i.from_held ? held_rd : byte_q;
      KIND_SEQ:  char_sel = upper;
      default:   char_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_count_q  <= '0;
      current_id_q <= '0;
      line_count_q <= 32'd1;
      held_count_q <= '0;
      flush_idx_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      seq_count_q  <= seq_count_d;
      current_id_q <= current_id_d;
      line_count_q <= line_count_d;
      held_count_q <= held_count_d;
      flush_idx_q  <= flush_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      byte_q <= byte_in_i;
      eoi_q  <= end_of_input_i;
    end
    if (cmd_i.push) begin
      out_kind_q    <= cmd_i.kind;
      out_char_q    <= char_sel;
      record_id_q   <= current_id_q;
      seq_length_q  <= (cmd_i.kind == KIND_REC_END) ? seq_count_q : '0;
      error_code_q  <= cmd_i.err;
      line_number_q <= line_count_q;
      out_last_q    <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_char_o    = out_char_q;
  assign record_id_o   = record_id_q;
  assign seq_length_o  = seq_length_q;
  assign error_code_o  = error_code_q;
  assign line_number_o = line_number_q;
  assign out_last_o    = out_last_q;

endmodule

[design/fsp_ctrl.sv]
// Controller: request sequencing, line phase tracking and result commands.
module fsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fsp_pkg::fsp_status_t status_i,
  output fsp_pkg::fsp_cmd_t    cmd_o
);
  import fsp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FLUSH,
    S_CHAR
  } state_e;

  typedef enum logic [2:0] {
    PH_START,
    PH_NAME,
    PH_AFTER_SPACE,
    PH_SEQ,
    PH_SKIP
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   header_seen_q, header_seen_d;
  logic   name_nonempty_q, name_nonempty_d;
  logic   trail_q, trail_d;
  logic   err_q, err_d;
  logic   flush_name_q, flush_name_d;
  logic   name_err;

  assign in_ready_o = (state_q == S_IDLE);

  // Header line closed without a single name character.
  assign name_err = ((phase_q == PH_NAME) || (phase_q == PH_AFTER_SPACE) ||
                     (phase_q == PH_SKIP)) && !name_nonempty_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.kind      = KIND_NAME;
    cmd_o.err       = ERR_NONE;
    state_d         = state_q;
    phase_d         = phase_q;
    header_seen_d   = header_seen_q;
    name_nonempty_d = name_nonempty_q;
    trail_d         = trail_q;
    err_d           = err_q;
    flush_name_d    = flush_name_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_EXEC;
        end
      end

      S_EXEC: begin
        if (err_q) begin
          state_d = S_IDLE;
        end else if (status_i.eoi) begin
          if (status_i.out_free) begin
            cmd_o.push = 1'b1;
            cmd_o.last = 1'b1;
            if (name_err) begin
              cmd_o.kind = KIND_ERROR;
              cmd_o.err  = ERR_EMPTY_NAME;
              err_d      = 1'b1;
            end else if (status_i.seq_zero) begin
              cmd_o.kind = KIND_ERROR;
              cmd_o.err  = ERR_EMPTY_SEQ;
              err_d      = 1'b1;
            end else begin
              cmd_o.kind   = KIND_REC_END;
              cmd_o.id_inc = 1'b1;
            end
            cmd_o.held_clr  = 1'b1;
            cmd_o.seq_clr   = 1'b1;
            cmd_o.line_rst  = 1'b1;
            phase_d         = PH_START;
            trail_d         = 1'b0;
            header_seen_d   = 1'b0;
            name_nonempty_d = 1'b0;
            state_d         = S_IDLE;
          end
        end else if (status_i.is_nl) begin
          if (!name_err || status_i.out_free) begin
            if (name_err) begin
              cmd_o.push = 1'b1;
              cmd_o.last = 1'b1;
              cmd_o.kind = KIND_ERROR;
              cmd_o.err  = ERR_EMPTY_NAME;
              err_d      = 1'b1;
            end
            cmd_o.held_clr = 1'b1;
            cmd_o.line_inc = 1'b1;
            phase_d        = PH_START;
            trail_d        = 1'b0;
            state_d        = S_IDLE;
          end
        end else begin
          case (phase_q)
            PH_START: begin
              if (status_i.is_blank) begin
                state_d = S_IDLE;
              end else if (status_i.is_gt) begin
                if (!header_seen_q || status_i.out_free) begin
                  if (header_seen_q) begin
                    cmd_o.push = 1'b1;
                    cmd_o.last = 1'b1;
                    if (status_i.seq_zero) begin
                      cmd_o.kind = KIND_ERROR;
                      cmd_o.err  = ERR_EMPTY_SEQ;
                      err_d      = 1'b1;
                    end else begin
                      cmd_o.kind    = KIND_REC_END;
                      cmd_o.id_inc  = 1'b1;
                      cmd_o.seq_clr = 1'b1;
                    end
                  end
                  cmd_o.held_clr  = 1'b1;
                  header_seen_d   = 1'b1;
                  name_nonempty_d = 1'b0;
                  phase_d         = PH_NAME;
                  state_d         = S_IDLE;
                end
              end else if (status_i.out_free) begin
                cmd_o.push = 1'b1;
                cmd_o.last = 1'b1;
                if (status_i.seq_ok) begin
                  cmd_o.kind    = KIND_SEQ;
                  cmd_o.seq_inc = 1'b1;
                end else begin
                  cmd_o.kind = KIND_ERROR;
                  cmd_o.err  = ERR_ILLEGAL_CHAR;
                  err_d      = 1'b1;
                end
                phase_d = PH_SEQ;
                state_d = S_IDLE;
              end
            end

            PH_NAME: begin
              if (status_i.is_space) begin
                phase_d = status_i.held_zero ? PH_SKIP : PH_AFTER_SPACE;
                state_d = S_IDLE;
              end else if (status_i.is_blank) begin
                if (!status_i.held_full) begin
                  cmd_o.held_wr = 1'b1;
                  state_d       = S_IDLE;
                end else if (status_i.out_free) begin
                  cmd_o.push = 1'b1;
                  cmd_o.last = 1'b1;
                  cmd_o.kind = KIND_ERROR;
                  cmd_o.err  = ERR_WS_OVERFLOW;
                  err_d      = 1'b1;
                  state_d    = S_IDLE;
                end
              end else if (status_i.held_zero) begin
                if (status_i.out_free) begin
                  cmd_o.push      = 1'b1;
                  cmd_o.last      = 1'b1;
                  cmd_o.kind      = KIND_NAME;
                  name_nonempty_d = 1'b1;
                  state_d         = S_IDLE;
                end
              end else begin
                cmd_o.flush_start = 1'b1;
                flush_name_d      = 1'b1;
                state_d           = S_FLUSH;
              end
            end

            PH_AFTER_SPACE: begin
              if (status_i.is_blank) begin
                state_d = S_IDLE;
              end else begin
                cmd_o.flush_start = 1'b1;
                flush_name_d      = 1'b0;
                state_d           = S_FLUSH;
              end
            end

            PH_SEQ: begin
              if (status_i.is_blank) begin
                trail_d = 1'b1;
                state_d = S_IDLE;
              end else if (status_i.out_free) begin
                cmd_o.push = 1'b1;
                cmd_o.last = 1'b1;
                if (trail_q || !status_i.seq_ok) begin
                  cmd_o.kind = KIND_ERROR;
                  cmd_o.err  = ERR_ILLEGAL_CHAR;
                  err_d      = 1'b1;
                end else begin
                  cmd_o.kind    = KIND_SEQ;
                  cmd_o.seq_inc = 1'b1;
                end
                state_d = S_IDLE;
              end
            end

            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.kind      = KIND_NAME;
          cmd_o.from_held = 1'b1;
          cmd_o.last      = status_i.flush_last && !flush_name_q;
          if (status_i.flush_last) begin
            cmd_o.held_clr  = 1'b1;
            name_nonempty_d = 1'b1;
            if (flush_name_q) begin
              state_d = S_CHAR;
            end else begin
              phase_d = PH_SKIP;
              state_d = S_IDLE;
            end
          end else begin
            cmd_o.flush_step = 1'b1;
          end
        end
      end

      S_CHAR: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.last = 1'b1;
          cmd_o.kind = KIND_NAME;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      phase_q         <= PH_START;
      header_seen_q   <= 1'b0;
      name_nonempty_q <= 1'b0;
      trail_q         <= 1'b0;
      err_q           <= 1'b0;
      flush_name_q    <= 1'b0;
    end else begin
      state_q         <= state_d;
      phase_q         <= phase_d;
      header_seen_q   <= header_seen_d;
      name_nonempty_q <= name_nonempty_d;
      trail_q         <= trail_d;
      err_q           <= err_d;
      flush_name_q    <= flush_name_d;
    end
  end

endmodule

[design/fsp_checker.sv]
// Port-level checker for the FASTA stream parser and its bind to the top level.
`include "fasta_stream_parser_defines.svh"

module fsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  out_char_i,
  input logic [31:0] seq_length_i,
  input logic [2:0]  error_code_i,
  input logic        out_last_i
);
  import fsp_pkg::*;

  // Stalled result holds its payload.
  `FSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_char_i) && $stable(error_code_i) && $stable(out_last_i), "result changed while stalled")

  // Error code present exactly on error results.
  `FSP_ASSERT_NOW(a_err_code, clk_i, rst_ni, out_valid_i, (out_kind_i == KIND_ERROR) == (error_code_i != ERR_NONE), "error code does not match result kind")

  // A record end always reports a non-empty sequence.
  `FSP_ASSERT_NOW(a_rec_len, clk_i, rst_ni, out_valid_i && (out_kind_i == KIND_REC_END), (seq_length_i != '0) && (out_char_i == '0), "bad record end")

  // Errors are sticky: nothing follows a delivered error.
  `FSP_ASSERT_NEXT(a_err_quiet, clk_i, rst_ni, out_valid_i && out_ready_i && (out_kind_i == KIND_ERROR), !out_valid_i, "result after error")

endmodule

bind fasta_stream_parser fsp_checker u_fsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_kind_i   (out_kind_o),
  .out_char_i   (out_char_o),
  .seq_length_i (seq_length_o),
  .error_code_i (error_code_o),
  .out_last_i   (out_last_o)
);

[sim/tb_fasta_stream_parser.sv]
// Self-checking testbench for the FASTA stream parser: directed table, random files, error tail.
`timescale 1ns / 1ps

module tb_fasta_stream_parser;
  import fsp_pkg::*;

  localparam int unsigned HELD         = HELD_DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 32;       // covers a full held-whitespace flush
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned PHASE_ITEMS  = 70;       // random requests per idling phase
  localparam string       NT_SET       = "ACGTURYKMSWBDHWNX-";

  // One result item as the block presents it.
  typedef struct packed {
    out_kind_e   kind;
    logic [7:0]  ch;
    logic [31:0] id;
    logic [31:0] len;
    err_code_e   err;
    logic [31:0] line;
    logic        last;
  } parse_result_t;

  localparam parse_result_t NO_RES = '0;

  // Directed row: one request, plus a hand-written result where it is obvious.
  typedef struct packed {
    logic [7:0]    b;
    logic          eoi;
    logic          typed;
    parse_result_t want;
  } stim_row_t;

  typedef enum logic [2:0] {
    LN_START, LN_NAME, LN_AFTER_SPACE, LN_SEQ, LN_SKIP
  } line_state_e;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [31:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_in_i      = '0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_char_o;
  logic [31:0] record_id_o;
  logic [31:0] seq_length_o;
  logic [2:0]  error_code_o;
  logic [31:0] line_number_o;
  logic        out_last_o;

  fasta_stream_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_in_i      (byte_in_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .out_char_o     (out_char_o),
    .record_id_o    (record_id_o),
    .seq_length_o   (seq_length_o),
    .error_code_o   (error_code_o),
    .line_number_o  (line_number_o),
    .out_last_o     (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: state, configuration and the results of the current request
  // ---------------------------------------------------------------------------
  line_state_e   lstate        = LN_START;
  bit            hdr_seen      = 1'b0;
  bit            name_has_char = 1'b0;
  bit            seq_gap       = 1'b0;   // blank seen on a sequence line
  bit            parse_dead    = 1'b0;   // sticky error
  logic [31:0]   first_id      = '0;
  logic [31:0]   rec_id        = '0;
  logic [31:0]   seq_len       = '0;
  logic [31:0]   line_no       = 32'd1;
  logic [7:0]    held_ws [HELD];
  int unsigned   held_n        = 0;
  parse_result_t step_out [$];

  parse_result_t pending_results [$];
  int unsigned   mismatch_cnt   = 0;
  int unsigned   items_sent     = 0;
  int unsigned   cycle_cnt      = 0;
  int unsigned   send_gap_pct   = 0;
  int unsigned   recv_stall_pct = 0;

  function automatic bit ws_byte(logic [7:0] b);
    return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic logic [7:0] seq_upper(logic [7:0] b);
    return (b >= CHAR_LC_A && b <= CHAR_LC_Z) ? b - CASE_DELTA : b;
  endfunction

  function automatic bit nt_ok(logic [7:0] c);
    for (int i = 0; i < NT_SET.len(); i++)
      if (NT_SET[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void post(out_kind_e k, logic [7:0] c, logic [31:0] n, err_code_e e);
    parse_result_t r;
    r.kind = k;
    r.ch   = c;
    r.id   = rec_id;
    r.len  = n;
    r.err  = e;
    r.line = line_no;
    r.last = 1'b0;
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void abort_parse(err_code_e e);
    parse_dead = 1'b1;
    post(KIND_ERROR, 8'h00, '0, e);
  endfunction

  // Held name whitespace goes out ahead of the next name character.
  function automatic void flush_ws();
    for (int unsigned i = 0; i < held_n; i++) begin
      post(KIND_NAME, held_ws[i], '0, ERR_NONE);
      name_has_char = 1'b1;
    end
    held_n = 0;
  endfunction

  function automatic void close_line();
    if (lstate inside {LN_NAME, LN_AFTER_SPACE, LN_SKIP} && !name_has_char)
      abort_parse(ERR_EMPTY_NAME);
    lstate  = LN_START;
    seq_gap = 1'b0;
    held_n  = 0;
  endfunction

  function automatic void seq_char(logic [7:0] b);
    logic [7:0] u;
    u = seq_upper(b);
    if (seq_gap || !nt_ok(u)) begin
      abort_parse(ERR_ILLEGAL_CHAR);
    end else begin
      post(KIND_SEQ, u, '0, ERR_NONE);
      if (seq_len != '1) seq_len++;
    end
  endfunction

  function automatic void open_header();
    if (hdr_seen) begin
      if (seq_len == 0) begin
        abort_parse(ERR_EMPTY_SEQ);
        return;
      end
      post(KIND_REC_END, 8'h00, seq_len, ERR_NONE);
      rec_id++;
      seq_len = '0;
    end
    hdr_seen      = 1'b1;
    name_has_char = 1'b0;
    held_n        = 0;
    lstate        = LN_NAME;
  endfunction

  function automatic void name_step(logic [7:0] b);
    if (b == CHAR_SPACE) begin
      lstate = (held_n != 0) ? LN_AFTER_SPACE : LN_SKIP;
    end else if (ws_byte(b)) begin
      if (held_n >= HELD) abort_parse(ERR_WS_OVERFLOW);
      else held_ws[held_n++] = b;
    end else begin
      flush_ws();
      post(KIND_NAME, b, '0, ERR_NONE);
      name_has_char = 1'b1;
    end
  endfunction

  // Results the block owes for one accepted request, left in step_out.
  function automatic void predict_parse(logic [7:0] b, logic eoi);
    step_out.delete();
    if (parse_dead) return;
    if (eoi) begin
      close_line();
      if (!parse_dead) begin
        if (seq_len == 0) begin
          abort_parse(ERR_EMPTY_SEQ);
        end else begin
          post(KIND_REC_END, 8'h00, seq_len, ERR_NONE);
          rec_id++;
        end
      end
      // fresh file; ids keep counting
      hdr_seen      = 1'b0;
      name_has_char = 1'b0;
      seq_len       = '0;
      line_no       = 32'd1;
    end else if (b == CHAR_NL) begin
      close_line();
      if (line_no != '1) line_no++;
    end else begin
      case (lstate)
        LN_START: begin
          if (!ws_byte(b)) begin
            if (b == CHAR_GT) begin
              open_header();
            end else begin
              lstate = LN_SEQ;
              seq_char(b);
            end
          end
        end
        LN_NAME: name_step(b);
        LN_AFTER_SPACE: begin
          if (!ws_byte(b)) begin
            flush_ws();
            lstate = LN_SKIP;
          end
        end
        LN_SEQ: begin
          if (ws_byte(b)) seq_gap = 1'b1;
          else seq_char(b);
        end
        default: ;
      endcase
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Drive one request and hold it until accepted; typed rows carry their own result.
  task automatic send_byte(input logic [7:0] b, input logic eoi,
                           input bit typed = 1'b0, input parse_result_t want = NO_RES);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    byte_in_i      <= b;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    predict_parse(b, eoi);
    if (typed) pending_results.insert(pending_results.size(), want);
    else foreach (step_out[i]) pending_results.insert(pending_results.size(), step_out[i]);
  endtask

  // Let every owed result come back, then give the block time to settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_first_id(input logic [31:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    first_id = v;
    rec_id   = first_id;
  endtask

  function automatic logic [7:0] pick_ws(bit with_space);
    case ($urandom_range(with_space ? 4 : 3))
      0:       return CHAR_TAB;
      1:       return 8'd11;
      2:       return 8'd12;
      3:       return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (ws_byte(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_NL);
    return b;
  endfunction

  // Legal nucleotide, lowercase half the time where that exists.
  function automatic logic [7:0] pick_nt();
    logic [7:0] c;
    c = NT_SET[$urandom_range(NT_SET.len() - 1)];
    if (c != "-" && $urandom_range(1) == 1) c = c + CASE_DELTA;
    return c;
  endfunction

  task automatic send_blanks(input int unsigned lo, input int unsigned hi, input bit with_space);
    repeat ($urandom_range(hi, lo)) send_byte(pick_ws(with_space), 1'b0);
  endtask

  // Header line: name chars with runs of held whitespace (never past the held depth),
  // then either a bare newline, dropped trailing whitespace, or a space and junk.
  task automatic send_header();
    send_blanks(0, 2, 1'b1);
    send_byte(CHAR_GT, 1'b0);
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(99) < 30) send_blanks(1, HELD, 1'b0);
      send_byte(pick_name_char(), 1'b0);
    end
    case ($urandom_range(2))
      0: ;
      1: send_blanks(1, HELD, 1'b0);
      default: begin
        send_blanks(0, HELD, 1'b0);
        send_byte(CHAR_SPACE, 1'b0);
        repeat ($urandom_range(5)) send_byte(pick_junk(), 1'b0);
      end
    endcase
    send_byte(CHAR_NL, 1'b0);
  endtask

  task automatic send_seq_line(input bit keep_nl);
    send_blanks(0, 2, 1'b1);
    repeat ($urandom_range(10, 1)) send_byte(pick_nt(), 1'b0);
    send_blanks(0, 2, 1'b1);
    if (keep_nl) send_byte(CHAR_NL, 1'b0);
  endtask

  // A well-formed file closed by end of input; now and then headerless.
  task automatic send_file();
    int unsigned nrec;
    int unsigned nlines;
    bit          bare;
    bare = ($urandom_range(9) == 0);
    if (bare || $urandom_range(4) == 0) send_seq_line(1'b1);
    if (!bare) begin
      nrec = $urandom_range(3, 1);
      for (int unsigned r = 0; r < nrec; r++) begin
        if ($urandom_range(4) == 0) begin
          send_blanks(0, 3, 1'b1);
          send_byte(CHAR_NL, 1'b0);
        end
        send_header();
        nlines = $urandom_range(2, 1);
        for (int unsigned l = 0; l < nlines; l++)
          send_seq_line(!(r == nrec - 1 && l == nlines - 1 && $urandom_range(1) == 1));
      end
    end
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unrequested result: kind %0d char %0h", out_kind_o, out_char_o);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind",    want.kind, out_kind_o);
        check_field("out_char",    want.ch,   out_char_o);
        check_field("record_id",   want.id,   record_id_o);
        check_field("seq_length",  want.len,  seq_length_o);
        check_field("error_code",  want.err,  error_code_o);
        check_field("line_number", want.line, line_number_o);
        check_field("out_last",    want.last, out_last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[fasta_stream_parser] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [23];

  initial begin : stimulus
    int unsigned phase_end;
    err_code_e   tail_err;
    logic [7:0]  bad;

    // Directed file, record ids from reset (0). Covers: sequence ahead of any header,
    // name bytes 0x00 and 0xFF, held tab/CR flushed by a name char, space ending a
    // name with whitespace held and a later byte flushing it, ignored header junk,
    // trailing blank on a sequence line, record end on a new header and on end of input.
    dir_rows = '{
      '{8'h61,      1'b0, 1'b1, '{KIND_SEQ, 8'h41, 32'd0, 32'd0, ERR_NONE, 32'd1, 1'b1}},
      '{8'h63,      1'b0, 1'b1, '{KIND_SEQ, 8'h43, 32'd0, 32'd0, ERR_NONE, 32'd1, 1'b1}},
      '{CHAR_SPACE, 1'b0, 1'b0, NO_RES},
      '{CHAR_NL,    1'b0, 1'b0, NO_RES},
      '{CHAR_GT,    1'b0, 1'b0, NO_RES},
      '{8'h00,      1'b0, 1'b1, '{KIND_NAME, 8'h00, 32'd0, 32'd0, ERR_NONE, 32'd2, 1'b1}},
      '{CHAR_TAB,   1'b0, 1'b0, NO_RES},
      '{CHAR_CR,    1'b0, 1'b0, NO_RES},
      '{8'hFF,      1'b0, 1'b0, NO_RES},
      '{8'd11,      1'b0, 1'b0, NO_RES},
      '{CHAR_SPACE, 1'b0, 1'b0, NO_RES},
      '{CHAR_SPACE, 1'b0, 1'b0, NO_RES},
      '{8'h78,      1'b0, 1'b0, NO_RES},
      '{8'h71,      1'b0, 1'b0, NO_RES},
      '{CHAR_NL,    1'b0, 1'b0, NO_RES},
      '{8'h67,      1'b0, 1'b0, NO_RES},
      '{8'h2D,      1'b0, 1'b0, NO_RES},
      '{CHAR_NL,    1'b0, 1'b0, NO_RES},
      '{CHAR_GT,    1'b0, 1'b1, '{KIND_REC_END, 8'h00, 32'd0, 32'd4, ERR_NONE, 32'd4, 1'b1}},
      '{8'h6E,      1'b0, 1'b0, NO_RES},
      '{CHAR_NL,    1'b0, 1'b0, NO_RES},
      '{8'h74,      1'b0, 1'b0, NO_RES},
      '{8'hA5,      1'b1, 1'b1, '{KIND_REC_END, 8'h00, 32'd1, 32'd1, ERR_NONE, 32'd5, 1'b1}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 15;
    recv_stall_pct = 84;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].want);

    // Three idling phases, each under its own first id: top of range (ids wrap),
    // zero, and a random one.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_first_id(32'hFFFF_FFFF);
        end
        1: begin
          send_gap_pct   = 84;
          recv_stall_pct = 15;
          write_first_id(32'h0000_0000);
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          write_first_id($urandom);
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_file();
    end

    // Errors are sticky and reset comes only once, so one error closes the run.
    tail_err = err_code_e'($urandom_range(ERR_WS_OVERFLOW, ERR_EMPTY_SEQ));
    case (tail_err)
      ERR_EMPTY_SEQ: begin
        // header straight after a header with no sequence
        send_byte(CHAR_GT, 1'b0);
        send_byte(pick_name_char(), 1'b0);
        send_byte(CHAR_NL, 1'b0);
        send_byte(CHAR_GT, 1'b0);
      end
      ERR_EMPTY_NAME: begin
        send_byte(CHAR_GT, 1'b0);
        if ($urandom_range(1) == 1) send_byte(CHAR_SPACE, 1'b0);
        send_byte(CHAR_NL, 1'b0);
      end
      ERR_ILLEGAL_CHAR: begin
        send_byte(pick_nt(), 1'b0);
        if ($urandom_range(1) == 1) begin
          // blank inside a sequence line
          send_byte(pick_ws(1'b1), 1'b0);
          send_byte(pick_nt(), 1'b0);
        end else begin
          do bad = 8'($urandom_range(255));
          while (ws_byte(bad) || nt_ok(seq_upper(bad)));
          send_byte(bad, 1'b0);
        end
      end
      default: begin
        // one more held byte than the buffer takes
        send_byte(CHAR_GT, 1'b0);
        send_byte(pick_name_char(), 1'b0);
        repeat (HELD + 1) send_byte(pick_ws(1'b0), 1'b0);
      end
    endcase
    // the block must now stay silent
    repeat (4) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("[fasta_stream_parser] OK");
    end else begin
      $display("[fasta_stream_parser] ERROR");
    end
    $finish;
  end

endmodule
